// File: rtl/crc8lf_pkg.sv
// ----------------------------------------------------------------------------
// crc8lf_pkg
// Shared types, codes and the CRC-8 byte update for the length-prefixed
// frame receiver.
// ----------------------------------------------------------------------------
package crc8lf_pkg;

    // CRC-8 (reflected 0x8C form) constants
    localparam logic [7:0] CRC_TOP = 8'h80;
    localparam logic [7:0] CRC_TAP = 8'h18;
    localparam logic [7:0] CRC_LSB = 8'h01;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register map (index = paddr[4:2])
    localparam int          ADDR_W        = 5;
    localparam logic [2:0] REG_START_MARKER = 3'd0;
    localparam logic [2:0] REG_MAX_FRAME    = 3'd1;
    localparam logic [2:0] REG_EXP_ADDRESS  = 3'd2;
    localparam logic [2:0] REG_EXP_COMMAND  = 3'd3;
    localparam logic [2:0] REG_CHECK_EN     = 3'd4;

    // Reset values of the registers
    localparam logic [7:0] RST_START_MARKER = 8'd27;
    localparam logic [8:0] RST_MAX_FRAME    = 9'd32;
    localparam logic [7:0] RST_EXP_ADDRESS  = 8'd16;
    localparam logic [7:0] RST_EXP_COMMAND  = 8'd0;
    localparam logic [1:0] RST_CHECK_EN     = 2'd0;

    // Shortest legal length byte
    localparam logic [7:0] MIN_LENGTH = 8'd4;

    // Frame status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_SHORT     = 3'd2,
        ST_LONG      = 3'd3,
        ST_BAD_ADDR  = 3'd4,
        ST_BAD_CMD   = 3'd5,
        ST_BAD_CRC   = 3'd6
    } status_t;

    // Role of one byte within its frame, decided by the front
    typedef enum logic [2:0] {
        KIND_START  = 3'd0,
        KIND_LENGTH = 3'd1,
        KIND_ADDR   = 3'd2,
        KIND_CMD    = 3'd3,
        KIND_BODY   = 3'd4,
        KIND_LAST   = 3'd5,
        KIND_LONG   = 3'd6,
        KIND_SHORT  = 3'd7
    } kind_t;

    // One queue entry: classified byte
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } entry_t;

    // Configuration seen by the back
    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] expected_address;
        logic [7:0] expected_command;
        logic [1:0] check_enables;
    } cfg_t;

    // Byte-wide CRC-8 update, LSB first
    function automatic logic [7:0] crc_add(input logic [7:0] crc_in,
                                           input logic [7:0] b_in);
        logic [7:0] crc;
        logic [7:0] b;
        crc = crc_in;
        b   = b_in;
        for (int k = 0; k < 8; k++) begin
            if (((b ^ crc) & CRC_LSB) != 8'd0) begin
                crc = CRC_TOP | ((crc ^ CRC_TAP) >> 1);
            end else begin
                crc = crc >> 1;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

// File: rtl/crc8lf_front.sv
// ----------------------------------------------------------------------------
// crc8lf_front
// Accepts received bytes, tracks position within the frame and tags each
// byte with its role before it goes into the queue.
// ----------------------------------------------------------------------------
module crc8lf_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    input  logic [8:0]           max_frame_bytes,
    input  logic                 q_full,
    output logic                 q_push,
    output crc8lf_pkg::entry_t   q_entry
);
    import crc8lf_pkg::*;

    logic [7:0] pos_reg,   pos_next;
    logic [8:0] total_reg, total_next;
    logic [8:0] len_total;
    logic [8:0] pos_plus;

    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;
    assign len_total = {1'b0, s_rx_byte} + 9'd1;
    assign pos_plus  = {1'b0, pos_reg} + 9'd1;

    // classify the beat and advance the frame position
    always_comb begin
        pos_next     = pos_reg;
        total_next   = total_reg;
        q_entry.data = s_rx_byte;
        q_entry.kind = KIND_BODY;
        priority if (pos_reg == 8'd0) begin
            q_entry.kind = KIND_START;
            pos_next     = 8'd1;
        end else if (pos_reg == 8'd1) begin
            // too long wins over too short
            if (len_total > max_frame_bytes) begin
                q_entry.kind = KIND_LONG;
                pos_next     = 8'd0;
            end else if (s_rx_byte < MIN_LENGTH) begin
                q_entry.kind = KIND_SHORT;
                pos_next     = 8'd0;
            end else begin
                q_entry.kind = KIND_LENGTH;
                pos_next     = 8'd2;
                total_next   = len_total;
            end
        end else if (pos_plus >= total_reg) begin
            q_entry.kind = KIND_LAST;
            pos_next     = 8'd0;
        end else begin
            if (pos_reg == 8'd2) begin
                q_entry.kind = KIND_ADDR;
            end else if (pos_reg == 8'd3) begin
                q_entry.kind = KIND_CMD;
            end else begin
                q_entry.kind = KIND_BODY;
            end
            pos_next = pos_plus[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 8'd0;
            total_reg <= 9'd0;
        end else if (q_push) begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

endmodule

// File: rtl/crc8lf_fifo.sv
// ----------------------------------------------------------------------------
// crc8lf_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module crc8lf_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  crc8lf_pkg::entry_t   push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output crc8lf_pkg::entry_t   head
);
    import crc8lf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    entry_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !do_pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not follow push");
`endif

endmodule

// File: rtl/crc8lf_back.sv
// ----------------------------------------------------------------------------
// crc8lf_back
// Runs the CRC over queued bytes, holds header fields and issues one status
// beat per frame through an output register.
// ----------------------------------------------------------------------------
module crc8lf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  crc8lf_pkg::cfg_t     cfg,
    input  logic                 q_not_empty,
    input  crc8lf_pkg::entry_t   q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_frame_status,
    output logic [7:0]           m_frame_address,
    output logic [7:0]           m_frame_command,
    output logic [7:0]           m_frame_length
);
    import crc8lf_pkg::*;

    logic [7:0] crc_reg;
    logic       start_ok_reg;
    logic [7:0] addr_reg, cmd_reg, len_reg;
    logic [7:0] crc_base, crc_upd;

    logic       m_valid_reg;
    status_t    status_reg, status_next;
    logic [7:0] oaddr_reg, oaddr_next;
    logic [7:0] ocmd_reg,  ocmd_next;
    logic [7:0] olen_reg,  olen_next;

    logic       emits;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign emits    = (q_head.kind == KIND_LAST) || (q_head.kind == KIND_LONG) ||
                      (q_head.kind == KIND_SHORT);
    assign q_pop    = q_not_empty && (!emits || out_free);

    assign crc_base = (q_head.kind == KIND_START) ? 8'd0 : crc_reg;
    assign crc_upd  = crc_add(crc_base, q_head.data);

    // result of a frame-ending beat
    always_comb begin
        oaddr_next  = addr_reg;
        ocmd_next   = cmd_reg;
        olen_next   = len_reg;
        status_next = ST_OK;
        unique case (q_head.kind)
            KIND_LONG, KIND_SHORT: begin
                oaddr_next  = 8'd0;
                ocmd_next   = 8'd0;
                olen_next   = q_head.data;
                status_next = (q_head.kind == KIND_LONG) ? ST_LONG : ST_SHORT;
            end
            default: begin
                priority if (!start_ok_reg) begin
                    status_next = ST_BAD_START;
                end else if (cfg.check_enables[0] && addr_reg != cfg.expected_address) begin
                    status_next = ST_BAD_ADDR;
                end else if (cfg.check_enables[1] && cmd_reg != cfg.expected_command) begin
                    status_next = ST_BAD_CMD;
                end else if (q_head.data != crc_reg) begin
                    status_next = ST_BAD_CRC;
                end else begin
                    status_next = ST_OK;
                end
            end
        endcase
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            unique case (q_head.kind)
                KIND_START: begin
                    start_ok_reg <= (q_head.data == cfg.start_marker);
                    crc_reg      <= crc_upd;
                end
                KIND_LENGTH: begin
                    len_reg <= q_head.data;
                    crc_reg <= crc_upd;
                end
                KIND_ADDR: begin
                    addr_reg <= q_head.data;
                    crc_reg  <= crc_upd;
                end
                KIND_CMD: begin
                    cmd_reg <= q_head.data;
                    crc_reg <= crc_upd;
                end
                KIND_BODY: begin
                    crc_reg <= crc_upd;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop && emits) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emits) begin
            status_reg <= status_next;
            oaddr_reg  <= oaddr_next;
            ocmd_reg   <= ocmd_next;
            olen_reg   <= olen_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_status  = status_reg;
    assign m_frame_address = oaddr_reg;
    assign m_frame_command = ocmd_reg;
    assign m_frame_length  = olen_reg;

`ifndef NO_ASSERTIONS
    a_short_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == ST_SHORT) |-> olen_reg < MIN_LENGTH)
        else $error("too short reported for legal length");
    a_early_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg == ST_SHORT || status_reg == ST_LONG))
        |-> (oaddr_reg == 8'd0 && ocmd_reg == 8'd0))
        else $error("early end carries header bytes");
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && emits) |-> out_free)
        else $error("result overwrites pending beat");
`endif

endmodule

// File: rtl/crc8_length_frame_receiver.sv
// A status beat is registered: the last byte of its frame passes through the
//   queue and is popped from it into the output register.
// Throughput: one byte per cycle while the queue has room; the byte-wide CRC
//   update sits in the back. A stalled output backs up through the queue to s_ready.
// Reset (aresetn low, synchronous) restores register defaults, empties the
//   queue and returns the receiver to waiting for a start byte.
// ----------------------------------------------------------------------------
// crc8_length_frame_receiver
// Length-prefixed frame receiver with CRC-8 check and APB register port.
// ----------------------------------------------------------------------------
module crc8_length_frame_receiver #(
    parameter int FIFO_DEPTH = crc8lf_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // byte input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    // status output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_frame_status,
    output logic [7:0]                    m_frame_address,
    output logic [7:0]                    m_frame_command,
    output logic [7:0]                    m_frame_length,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crc8lf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import crc8lf_pkg::*;

    logic [7:0] start_marker_reg;
    logic [8:0] max_frame_reg;
    logic [7:0] exp_addr_reg;
    logic [7:0] exp_cmd_reg;
    logic [1:0] check_en_reg;
    logic       wr_en;
    logic [2:0] reg_idx;
    cfg_t       cfg;

    logic       q_full, q_push, q_pop, q_not_empty;
    entry_t     q_entry, q_head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= RST_START_MARKER;
            max_frame_reg    <= RST_MAX_FRAME;
            exp_addr_reg     <= RST_EXP_ADDRESS;
            exp_cmd_reg      <= RST_EXP_COMMAND;
            check_en_reg     <= RST_CHECK_EN;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_MARKER: start_marker_reg <= pwdata[7:0];
                REG_MAX_FRAME:    max_frame_reg    <= pwdata[8:0];
                REG_EXP_ADDRESS:  exp_addr_reg     <= pwdata[7:0];
                REG_EXP_COMMAND:  exp_cmd_reg      <= pwdata[7:0];
                REG_CHECK_EN:     check_en_reg     <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_START_MARKER: prdata = {24'd0, start_marker_reg};
            REG_MAX_FRAME:    prdata = {23'd0, max_frame_reg};
            REG_EXP_ADDRESS:  prdata = {24'd0, exp_addr_reg};
            REG_EXP_COMMAND:  prdata = {24'd0, exp_cmd_reg};
            REG_CHECK_EN:     prdata = {30'd0, check_en_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.start_marker     = start_marker_reg;
    assign cfg.expected_address = exp_addr_reg;
    assign cfg.expected_command = exp_cmd_reg;
    assign cfg.check_enables    = check_en_reg;

    crc8lf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .max_frame_bytes (max_frame_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_entry)
    );

    crc8lf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    crc8lf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_status  (m_frame_status),
        .m_frame_address (m_frame_address),
        .m_frame_command (m_frame_command),
        .m_frame_length  (m_frame_length)
    );

endmodule
